// ----- src/ssd_pkg.sv -----
// Shared types, codes and constants of the symmetric difference block.
// Used by every module under src; depends on nothing.
package ssd_pkg;

    localparam int KEY_W          = 32;
    localparam int LIST_DEPTH_DEF = 16;
    localparam int CMD_W          = 2;
    localparam int FLAG_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Bit positions of the flags in the result tuser.
    localparam int FLAG_EMPTY = 0;
    localparam int FLAG_OVF   = 1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             empty;
        logic             ovf;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } res_req_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ----- src/set_symmetric_difference.sv -----
// Top level of the symmetric difference block: stream ports around the core.
// Depends on ssd_pkg, ssd_core and ssd_out.
//
//   Channel | Direction | Words carried
//   s_axis  | in        | load A, load B, compute, clear commands with a key
//   m_axis  | out       | keys of the difference, tlast on the final one
//
// Load and clear words are accepted back to back.
// A compute word fetches each candidate (CFETCH, CLOAD), probes the other list and then
// its own earlier entries (SADDR, SCMP per probe, SADDR to end a phase) and emits a survivor;
// each list end passes CFETCH, the final word FINISH, and s_axis_tready stays low until then.
// Reset is synchronous and clears counts and flags.
// A stalled m_axis holds the sequencer at its next result word.
module set_symmetric_difference #(
    parameter int LIST_DEPTH = ssd_pkg::LIST_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ssd_pkg::KEY_W-1:0]  s_axis_tdata,   // key_in
    input  logic [ssd_pkg::CMD_W-1:0]  s_axis_tuser,   // command
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ssd_pkg::KEY_W-1:0]  m_axis_tdata,   // key_out
    output logic                       m_axis_tlast,
    output logic [ssd_pkg::FLAG_W-1:0] m_axis_tuser    // empty_res, overflowed
);

    ssd_pkg::res_req_t res_req;
    ssd_pkg::res_t     m_res;
    logic              res_ready;

    ssd_core #(.LIST_DEPTH(LIST_DEPTH)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_cmd     (ssd_pkg::cmd_t'(s_axis_tuser)),
        .s_key     (s_axis_tdata),
        .res_o     (res_req),
        .res_ready (res_ready)
    );

    ssd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_i     (res_req),
        .res_ready (res_ready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (m_res)
    );

    assign m_axis_tdata                      = m_res.key;
    assign m_axis_tlast                      = m_res.last;
    assign m_axis_tuser[ssd_pkg::FLAG_EMPTY] = m_res.empty;
    assign m_axis_tuser[ssd_pkg::FLAG_OVF]   = m_res.ovf;

endmodule

// ----- src/ssd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on ssd_pkg for the address width helper.
module ssd_ram #(
    parameter int WIDTH = ssd_pkg::KEY_W,
    parameter int DEPTH = ssd_pkg::LIST_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [ssd_pkg::addr_w(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [ssd_pkg::addr_w(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/ssd_core.sv -----
// Command decoder, list stores and the compare sequencer of the block.
// Depends on ssd_pkg and ssd_ram.
module ssd_core #(
    parameter int LIST_DEPTH = ssd_pkg::LIST_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ssd_pkg::cmd_t             s_cmd,
    input  logic [ssd_pkg::KEY_W-1:0] s_key,
    output ssd_pkg::res_req_t         res_o,
    input  logic                      res_ready
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = ssd_pkg::addr_w(LIST_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CFETCH = 7'b0000010,
        ST_CLOAD  = 7'b0000100,
        ST_SADDR  = 7'b0001000,
        ST_SCMP   = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             cnt_a_reg, cnt_a_next;
    logic [CW-1:0]             cnt_b_reg, cnt_b_next;
    logic                      ovf_reg, ovf_next;
    logic                      pass_reg, pass_next;
    logic                      ph_reg, ph_next;
    logic                      sel_reg, sel_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [CW-1:0]             j_reg, j_next;
    logic [ssd_pkg::KEY_W-1:0] cand_reg, cand_next;
    logic [ssd_pkg::KEY_W-1:0] pend_reg, pend_next;
    logic                      pend_vld_reg, pend_vld_next;

    logic                      we_a, we_b;
    logic [AW-1:0]             raddr;
    logic [ssd_pkg::KEY_W-1:0] rd_a, rd_b, rdata;
    logic [CW-1:0]             cnt_own, cnt_other, limit;
    logic                      hit;

    ssd_ram #(.WIDTH(ssd_pkg::KEY_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (s_key),
        .raddr (raddr),
        .rdata (rd_a)
    );

    ssd_ram #(.WIDTH(ssd_pkg::KEY_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (s_key),
        .raddr (raddr),
        .rdata (rd_b)
    );

    assign rdata     = sel_reg ? rd_b : rd_a;
    assign cnt_own   = pass_reg ? cnt_b_reg : cnt_a_reg;
    assign cnt_other = pass_reg ? cnt_a_reg : cnt_b_reg;
    assign limit     = ph_reg ? i_reg : cnt_other;
    assign raddr     = (state_reg == ST_CFETCH) ? i_reg[AW-1:0] : j_reg[AW-1:0];
    assign hit       = (rdata == cand_reg);
    assign s_ready   = (state_reg == ST_IDLE);

    // A candidate survives when it is absent from the other list and from the earlier
    // entries of its own list; an earlier equal entry has already been emitted.
    always_comb begin
        state_next    = state_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        ovf_next      = ovf_reg;
        pass_next     = pass_reg;
        ph_next       = ph_reg;
        sel_next      = sel_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cand_next     = cand_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        we_a          = 1'b0;
        we_b          = 1'b0;
        res_o         = '0;
        res_o.res.ovf = ovf_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_cmd)
                        ssd_pkg::CMD_LOAD_A: begin
                            if (cnt_a_reg < CW'(LIST_DEPTH)) begin
                                we_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ssd_pkg::CMD_LOAD_B: begin
                            if (cnt_b_reg < CW'(LIST_DEPTH)) begin
                                we_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ssd_pkg::CMD_COMPUTE: begin
                            pass_next     = 1'b0;
                            i_next        = '0;
                            pend_vld_next = 1'b0;
                            state_next    = ST_CFETCH;
                        end
                        ssd_pkg::CMD_CLEAR: begin
                            cnt_a_next = '0;
                            cnt_b_next = '0;
                            ovf_next   = 1'b0;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CFETCH: begin
                if (i_reg >= cnt_own) begin
                    if (!pass_reg) begin
                        pass_next = 1'b1;
                        i_next    = '0;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    sel_next   = pass_reg;
                    state_next = ST_CLOAD;
                end
            end
            ST_CLOAD: begin
                cand_next  = rdata;
                j_next     = '0;
                ph_next    = 1'b0;
                state_next = ST_SADDR;
            end
            ST_SADDR: begin
                if (j_reg >= limit) begin
                    if (!ph_reg) begin
                        ph_next = 1'b1;
                        j_next  = '0;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    sel_next   = ph_reg ? pass_reg : ~pass_reg;
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP: begin
                if (hit) begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_CFETCH;
                end else begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_SADDR;
                end
            end
            ST_EMIT: begin
                res_o.valid   = pend_vld_reg;
                res_o.res.key = pend_reg;
                if (res_ready) begin
                    pend_next     = cand_reg;
                    pend_vld_next = 1'b1;
                    i_next        = i_reg + CW'(1);
                    state_next    = ST_CFETCH;
                end
            end
            ST_FINISH: begin
                res_o.valid     = 1'b1;
                res_o.res.key   = pend_vld_reg ? pend_reg : '0;
                res_o.res.last  = 1'b1;
                res_o.res.empty = ~pend_vld_reg;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            ovf_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_a_reg    <= cnt_a_next;
            cnt_b_reg    <= cnt_b_next;
            ovf_reg      <= ovf_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pass_reg <= pass_next;
        ph_reg   <= ph_next;
        sel_reg  <= sel_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        cand_reg <= cand_next;
        pend_reg <= pend_next;
    end

endmodule

// ----- src/ssd_out.sv -----
// Output register stage that holds one result word until the sink takes it.
// Depends on ssd_pkg for the result types.
module ssd_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssd_pkg::res_req_t res_i,
    output logic              res_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ssd_pkg::res_t     m_res
);

    logic          valid_reg, valid_next;
    ssd_pkg::res_t res_reg, res_next;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (res_ready) begin
            valid_next = res_i.valid;
            if (res_i.valid) begin
                res_next = res_i.res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

// ----- src/ssd_checker.sv -----
// Port-level checks of the symmetric difference block, bound to its top level.
// Depends on ssd_pkg and set_symmetric_difference.
module ssd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [ssd_pkg::CMD_W-1:0]  s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [ssd_pkg::KEY_W-1:0]  m_axis_tdata,
    input logic                       m_axis_tlast,
    input logic [ssd_pkg::FLAG_W-1:0] m_axis_tuser
);

    logic s_take;

    assign s_take = s_axis_tvalid && s_axis_tready;

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // An empty result closes its run and carries a zero key.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[ssd_pkg::FLAG_EMPTY]
            |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty result word is not a zero final word");

    // A compute word starts a run, so the input side closes in the next cycle.
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && (s_axis_tuser == ssd_pkg::CMD_COMPUTE) |=> !s_axis_tready)
        else $error("input still open after a compute word");

    // Load and clear words leave the input side open in the next cycle.
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && (s_axis_tuser != ssd_pkg::CMD_COMPUTE) |=> s_axis_tready)
        else $error("input closed after a load or clear word");

endmodule

bind set_symmetric_difference ssd_checker u_ssd_checker (.*);
